// File: sv/sbes_pkg.sv
// Shared types and constants for the sonar burst and echo sequencer.
// Used by sbes_cfg, sbes_core and the top level; depends on nothing.
`timescale 1ns / 1ps

package sbes_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int MAX_CHANNELS     = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;
    localparam int BURST_W    = 8;
    localparam int LEVEL_W    = 16;
    localparam int SENSORS    = 4;
    localparam int SENSOR_W   = 2;
    localparam int DRIVE_W    = 4;
    localparam int COUNT_W    = 8;

    localparam logic [COUNT_W-1:0] PACK_QUALIFY = 8'd20;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;

    localparam logic [TICK_W-1:0]   PERIOD_RST   = 16'd1020;
    localparam logic [BURST_W-1:0]  BURST_RST    = 8'd48;
    localparam logic [TICK_W-1:0]   BLANKING_RST = 16'd72;
    localparam logic [LEVEL_W-1:0]  LEVEL_RST    = 16'(1080 / 2);
    localparam logic [SENSORS-1:0]  MASK_RST     = 4'd0;
    localparam logic [TICK_W-1:0]   GAP_RST      = 16'd10;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_EDGE = 1'b1
    } op_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD   = 3'd0,
        REG_BURST    = 3'd1,
        REG_BLANKING = 3'd2,
        REG_LEVEL    = 3'd3,
        REG_MASK     = 3'd4,
        REG_ONE_SHOT = 3'd5,
        REG_FIRE_EN  = 3'd6,
        REG_GAP      = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic [TICK_W-1:0]  period_ticks;
        logic [BURST_W-1:0] burst_ticks;
        logic [TICK_W-1:0]  blanking_ticks;
        logic [LEVEL_W-1:0] drive_level;
        logic [SENSORS-1:0] sensor_disable_mask;
        logic               one_shot;
        logic               fire_enable;
        logic [TICK_W-1:0]  gap_limit;
        logic               rearm;
    } cfg_t;

    typedef struct packed {
        logic [DRIVE_W-1:0]  channel_drive;
        logic [LEVEL_W-1:0]  drive_compare;
        logic [SENSORS-1:0]  listening;
        logic                reading_valid;
        logic [TICK_W-1:0]   reading_time;
        logic [COUNT_W-1:0]  pulse_count;
        logic [SENSOR_W-1:0] echo_sensor;
    } result_t;

endpackage

// File: sv/sonar_burst_and_echo_sequencer.sv
// An accepted item waits in the input register; its result moves to the
// result register, with out_valid high, once the output is free. Throughput:
// one item per cycle while no result stalls; an input register and a result
// register separate the two channels, and the state update fits between them.
// Reset: asynchronous, active low; clears all sequencer state and loads the
// register defaults. Depends on sbes_pkg, sbes_cfg and sbes_core.
`timescale 1ns / 1ps

module sonar_burst_and_echo_sequencer
    import sbes_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [SENSOR_W-1:0]   sensor,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DRIVE_W-1:0]    channel_drive,
    output logic [LEVEL_W-1:0]    drive_compare,
    output logic [SENSORS-1:0]    listening,
    output logic                  reading_valid,
    output logic [TICK_W-1:0]     reading_time,
    output logic [COUNT_W-1:0]    pulse_count,
    output logic [SENSOR_W-1:0]   echo_sensor
);

    cfg_t                cfg;
    result_t             res_next;
    result_t             res_reg;
    logic                in_valid_reg;
    logic                opcode_reg;
    logic [SENSOR_W-1:0] sensor_reg;
    logic                out_valid_reg;
    logic                out_free;
    logic                step;

    sbes_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sbes_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .opcode (opcode_reg),
        .sensor (sensor_reg),
        .cfg    (cfg),
        .res    (res_next)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg <= opcode;
            sensor_reg <= sensor;
        end
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_drive = res_reg.channel_drive;
    assign drive_compare = res_reg.drive_compare;
    assign listening     = res_reg.listening;
    assign reading_valid = res_reg.reading_valid;
    assign reading_time  = res_reg.reading_time;
    assign pulse_count   = res_reg.pulse_count;
    assign echo_sensor   = res_reg.echo_sensor;

    a_reading_qualified: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.reading_valid |-> res_reg.pulse_count > PACK_QUALIFY)
        else $error("Reading reported before the pack qualified.");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("Processed item did not reach the result register.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !step)
        else $error("Stalled result overwritten by a new item.");

endmodule

// File: sv/sbes_cfg.sv
// Configuration register file for the sonar sequencer.
// Depends on sbes_pkg; feeds the settings and a re-arm pulse to sbes_core.
`timescale 1ns / 1ps

module sbes_cfg
    import sbes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [TICK_W-1:0]  period_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [TICK_W-1:0]  blanking_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [SENSORS-1:0] mask_reg;
    logic               one_shot_reg;
    logic               fire_en_reg;
    logic [TICK_W-1:0]  gap_reg;
    logic               wr_en;
    logic               rearm;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_RST;
            burst_reg    <= BURST_RST;
            blanking_reg <= BLANKING_RST;
            level_reg    <= LEVEL_RST;
            mask_reg     <= MASK_RST;
            one_shot_reg <= 1'b0;
            fire_en_reg  <= 1'b1;
            gap_reg      <= GAP_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_PERIOD:   period_reg   <= cfg_data;
                REG_BURST:    burst_reg    <= cfg_data[BURST_W-1:0];
                REG_BLANKING: blanking_reg <= cfg_data;
                REG_LEVEL:    level_reg    <= cfg_data;
                REG_MASK:     mask_reg     <= cfg_data[SENSORS-1:0];
                REG_ONE_SHOT: one_shot_reg <= cfg_data[0];
                REG_FIRE_EN:  fire_en_reg  <= cfg_data[0];
                REG_GAP:      gap_reg      <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign rearm = wr_en && (cfg_reg_e'(cfg_index) == REG_FIRE_EN);

    always_comb
    begin
        cfg.period_ticks        = period_reg;
        cfg.burst_ticks         = burst_reg;
        cfg.blanking_ticks      = blanking_reg;
        cfg.drive_level         = level_reg;
        cfg.sensor_disable_mask = mask_reg;
        cfg.one_shot            = one_shot_reg;
        cfg.fire_enable         = fire_en_reg;
        cfg.gap_limit           = gap_reg;
        cfg.rearm               = rearm;
    end

endmodule

// File: sv/sbes_core.sv
// Sequencer state and the single-pass update for one tick or echo edge item.
// Depends on sbes_pkg; driven by the top level's input register and sbes_cfg.
`timescale 1ns / 1ps

module sbes_core
    import sbes_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                opcode,
    input  logic [SENSOR_W-1:0] sensor,
    input  cfg_t                cfg,
    output result_t             res
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

    logic [TICK_W-1:0]       tick_count_reg, tick_count_next;
    logic [CH_W-1:0]         channel_reg, channel_next;
    logic [NUM_CHANNELS-1:0] drive_on_reg, drive_on_next;
    logic                    shot_done_reg, shot_done_next;
    logic                    listen_open_reg, listen_open_next;
    logic [TICK_W-1:0]       last_front_reg, last_front_next;
    logic [TICK_W-1:0]       first_front_reg, first_front_next;
    logic [COUNT_W-1:0]      edge_count_reg, edge_count_next;

    logic [TICK_W:0]         burst_end;
    logic [TICK_W:0]         listen_start;
    logic [TICK_W-1:0]       tick_inc;
    logic [TICK_W-1:0]       gap;
    logic                    edge_ok;
    logic                    valid;
    logic [SENSORS-1:0]      listen_bits;
    logic [MAX_CHANNELS-1:0] drive_ext;

    assign burst_end    = (TICK_W+1)'(cfg.burst_ticks);
    assign listen_start = burst_end + (TICK_W+1)'(cfg.blanking_ticks);
    assign tick_inc     = tick_count_reg + 1'b1;
    assign gap          = tick_count_reg - last_front_reg;
    assign edge_ok      = listen_open_reg && !cfg.sensor_disable_mask[sensor];

    always_comb
    begin
        tick_count_next  = tick_count_reg;
        channel_next     = channel_reg;
        drive_on_next    = drive_on_reg;
        shot_done_next   = shot_done_reg;
        listen_open_next = listen_open_reg;
        last_front_next  = last_front_reg;
        first_front_next = first_front_reg;
        edge_count_next  = edge_count_reg;
        valid            = 1'b0;

        if (op_e'(opcode) == OP_TICK)
        begin
            if (tick_count_reg == '0 && cfg.fire_enable && !shot_done_reg)
            begin
                drive_on_next = NUM_CHANNELS'(1) << channel_reg;
                if (cfg.one_shot)
                begin
                    shot_done_next = 1'b1;
                end
            end
            if ((TICK_W+1)'(tick_count_reg) > burst_end)
            begin
                drive_on_next = '0;
                if ((TICK_W+1)'(tick_count_reg) == burst_end + 1'b1)
                begin
                    channel_next = (channel_reg == CH_LAST) ? '0 : channel_reg + 1'b1;
                end
            end
            if ((TICK_W+1)'(tick_count_reg) > listen_start)
            begin
                listen_open_next = 1'b1;
            end
            tick_count_next = tick_inc;
            if (tick_inc >= cfg.period_ticks)
            begin
                tick_count_next  = '0;
                listen_open_next = 1'b0;
                last_front_next  = '0;
                first_front_next = '0;
                edge_count_next  = '0;
            end
        end
        else if (edge_ok)
        begin
            last_front_next = tick_count_reg;
            if (gap > cfg.gap_limit && edge_count_reg < PACK_QUALIFY)
            begin
                edge_count_next  = COUNT_W'(1);
                first_front_next = tick_count_reg;
            end
            else if (edge_count_reg < COUNT_MAX)
            begin
                edge_count_next = edge_count_reg + 1'b1;
            end
            valid = edge_count_next > PACK_QUALIFY;
        end

        if (cfg.rearm)
        begin
            shot_done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            channel_reg     <= '0;
            drive_on_reg    <= '0;
            shot_done_reg   <= 1'b0;
            listen_open_reg <= 1'b0;
            last_front_reg  <= '0;
            first_front_reg <= '0;
            edge_count_reg  <= '0;
        end
        else
        begin
            if (step)
            begin
                tick_count_reg  <= tick_count_next;
                channel_reg     <= channel_next;
                drive_on_reg    <= drive_on_next;
                listen_open_reg <= listen_open_next;
                last_front_reg  <= last_front_next;
                first_front_reg <= first_front_next;
                edge_count_reg  <= edge_count_next;
            end
            if (step || cfg.rearm)
            begin
                shot_done_reg <= shot_done_next;
            end
        end
    end

    assign listen_bits = listen_open_next ? ~cfg.sensor_disable_mask : '0;
    assign drive_ext   = MAX_CHANNELS'(drive_on_next);

    always_comb
    begin
        res.channel_drive = drive_ext[DRIVE_W-1:0];
        res.drive_compare = (|drive_on_next) ? cfg.drive_level : '0;
        res.listening     = listen_bits;
        res.reading_valid = valid;
        res.reading_time  = valid ? first_front_next : '0;
        res.pulse_count   = edge_count_next;
        res.echo_sensor   = (op_e'(opcode) == OP_EDGE) ? sensor : '0;
    end

    a_drive_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(drive_on_reg))
        else $error("More than one transmit channel driven.");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        channel_reg <= CH_LAST)
        else $error("Channel index beyond the channel count.");

    a_closed_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        !listen_open_reg |-> edge_count_reg == '0)
        else $error("Edges counted while listening is closed.");

    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && op_e'(opcode) == OP_EDGE && !edge_ok |=>
            $stable(edge_count_reg) && $stable(last_front_reg))
        else $error("A rejected edge changed the echo state.");

endmodule

// File: verif/tb.sv
// Self-checking testbench for sonar_burst_and_echo_sequencer: an in-file
// predictor tracks ticks, channel drive, listening and echo packs per item.
// Depends on sbes_pkg and the RTL top level; needs nothing else.
`timescale 1ns / 1ps

module tb;
    import sbes_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int IDLE_PCT    = 24;

    class sonar_scoreboard;
        logic [TICK_W-1:0]  period;
        logic [BURST_W-1:0] burst;
        logic [TICK_W-1:0]  blanking;
        logic [LEVEL_W-1:0] level;
        logic [SENSORS-1:0] dis_mask;
        logic               one_shot;
        logic               fire_en;
        logic [TICK_W-1:0]  gap_lim;

        logic [TICK_W-1:0]   ticks;
        logic [SENSOR_W-1:0] chan;
        logic [DRIVE_W-1:0]  drive;
        logic                shot_done;
        logic                listen;
        logic [TICK_W-1:0]   last_front;
        logic [TICK_W-1:0]   first_front;
        logic [COUNT_W-1:0]  edges;

        result_t expected_q[$];
        int errors;
        int checked;
        int items;
        int readings;
        int peak_count;

        function new();
            period      = PERIOD_RST;
            burst       = BURST_RST;
            blanking    = BLANKING_RST;
            level       = LEVEL_RST;
            dis_mask    = MASK_RST;
            one_shot    = 1'b0;
            fire_en     = 1'b1;
            gap_lim     = GAP_RST;
            ticks       = '0;
            chan        = '0;
            drive       = '0;
            shot_done   = 1'b0;
            listen      = 1'b0;
            last_front  = '0;
            first_front = '0;
            edges       = '0;
        endfunction

        function void write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] d);
            case (r)
                REG_PERIOD:   period   = d;
                REG_BURST:    burst    = d[BURST_W-1:0];
                REG_BLANKING: blanking = d;
                REG_LEVEL:    level    = d;
                REG_MASK:     dis_mask = d[SENSORS-1:0];
                REG_ONE_SHOT: one_shot = d[0];
                REG_FIRE_EN:
                begin
                    fire_en   = d[0];
                    shot_done = 1'b0;
                end
                REG_GAP:      gap_lim  = d;
                default:      ;
            endcase
        endfunction

        function logic [SENSORS-1:0] open_sensors();
            return listen ? ~dis_mask : '0;
        endfunction

        function void advance_tick();
            int unsigned count;
            int unsigned burst_end;
            count = ticks;
            burst_end = burst;
            if (count == 0 && fire_en && !shot_done) begin
                drive = DRIVE_W'(1 << chan);
                if (one_shot)
                    shot_done = 1'b1;
            end
            if (count > burst_end) begin
                drive = '0;
                if (count == burst_end + 1)
                    chan = (int'(chan) == NUM_CHANNELS_DEF - 1) ? '0 : chan + 1'b1;
            end
            if (count > burst_end + int'(blanking))
                listen = 1'b1;
            ticks = ticks + 1'b1;
            if (ticks >= period) begin
                ticks       = '0;
                listen      = 1'b0;
                last_front  = '0;
                first_front = '0;
                edges       = '0;
            end
        endfunction

        function bit take_edge(logic [SENSOR_W-1:0] s);
            logic [SENSORS-1:0] open_now;
            logic [TICK_W-1:0]  gap;
            open_now = open_sensors();
            if (!open_now[s])
                return 1'b0;
            gap = ticks - last_front;
            last_front = ticks;
            if (gap > gap_lim && edges < PACK_QUALIFY) begin
                edges = COUNT_W'(1);
                first_front = ticks;
            end
            else if (edges < COUNT_MAX) begin
                edges = edges + 1'b1;
            end
            return edges > PACK_QUALIFY;
        endfunction

        function void note_item(op_e op, logic [SENSOR_W-1:0] s);
            result_t r;
            bit      hit;
            hit = 1'b0;
            if (op == OP_TICK)
                advance_tick();
            else
                hit = take_edge(s);
            r.channel_drive = drive;
            r.drive_compare = (drive != '0) ? level : '0;
            r.listening     = open_sensors();
            r.reading_valid = hit;
            r.reading_time  = hit ? first_front : '0;
            r.pulse_count   = edges;
            r.echo_sensor   = (op == OP_EDGE) ? s : '0;
            expected_q.push_back(r);
            items++;
            if (hit)
                readings++;
            if (int'(edges) > peak_count)
                peak_count = edges;
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("Mismatch at result %0d: %s", checked, msg);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
                note_error($sformatf("%s expected %0d, got %0d", name, want, got));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                note_error("result arrived with no item outstanding");
                return;
            end
            want = expected_q.pop_front();
            check_field("channel_drive", want.channel_drive, got.channel_drive);
            check_field("drive_compare", want.drive_compare, got.drive_compare);
            check_field("listening", want.listening, got.listening);
            check_field("reading_valid", want.reading_valid, got.reading_valid);
            check_field("reading_time", want.reading_time, got.reading_time);
            check_field("pulse_count", want.pulse_count, got.pulse_count);
            check_field("echo_sensor", want.echo_sensor, got.echo_sensor);
            checked++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
                note_error($sformatf("%0d results never arrived", expected_q.size()));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  opcode    = 1'b0;
    logic [SENSOR_W-1:0]   sensor    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [DRIVE_W-1:0]    channel_drive;
    logic [LEVEL_W-1:0]    drive_compare;
    logic [SENSORS-1:0]    listening;
    logic                  reading_valid;
    logic [TICK_W-1:0]     reading_time;
    logic [COUNT_W-1:0]    pulse_count;
    logic [SENSOR_W-1:0]   echo_sensor;

    sonar_scoreboard board;
    bit steady = 1'b0;
    int settings_used = 0;
    int cycles = 0;

    sonar_burst_and_echo_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .sensor        (sensor),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel_drive (channel_drive),
        .drive_compare (drive_compare),
        .listening     (listening),
        .reading_valid (reading_valid),
        .reading_time  (reading_time),
        .pulse_count   (pulse_count),
        .echo_sensor   (echo_sensor)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, board.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                board.check_result({channel_drive, drive_compare, listening, reading_valid,
                                    reading_time, pulse_count, echo_sensor});
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_settings(input logic [TICK_W-1:0] per, input logic [BURST_W-1:0] bur,
                                  input logic [TICK_W-1:0] blank, input logic [LEVEL_W-1:0] lvl,
                                  input logic [SENSORS-1:0] mask, input logic shot,
                                  input logic fire, input logic [TICK_W-1:0] gap);
        logic [CFG_DATA_W-1:0] vals [8];
        cfg_reg_e r;
        vals = '{per, CFG_DATA_W'(bur), blank, lvl, CFG_DATA_W'(mask),
                 CFG_DATA_W'(shot), CFG_DATA_W'(fire), gap};
        r = r.first();
        do begin
            cfg_valid <= 1'b1;
            cfg_index <= r;
            cfg_data  <= vals[r];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            board.write_reg(r, vals[r]);
            r = r.next();
        end while (r != r.first());
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_item(input op_e op, input logic [SENSOR_W-1:0] s);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        sensor   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_item(op, s);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input logic [TICK_W-1:0] per, input logic [BURST_W-1:0] bur,
                             input logic [TICK_W-1:0] blank, input logic [LEVEL_W-1:0] lvl,
                             input logic [SENSORS-1:0] mask, input logic shot,
                             input logic fire, input logic [TICK_W-1:0] gap,
                             input int count, input int edge_pct);
        write_settings(per, bur, blank, lvl, mask, shot, fire, gap);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < edge_pct)
                send_item(OP_EDGE, SENSOR_W'($urandom_range(SENSORS - 1)));
            else
                send_item(OP_TICK, SENSOR_W'($urandom_range(SENSORS - 1)));
        end
        drain();
    endtask

    initial
    begin
        logic [SENSOR_W-1:0] open_set [3];
        open_set = '{2'd0, 2'd2, 2'd3};
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Edges before listening opens are rejected; the first tick fires channel 0.
        send_item(OP_EDGE, 2'd3);
        send_item(OP_TICK, 2'd0);
        send_item(OP_TICK, 2'd3);
        drain();

        // A short period above the running count, then a masked edge and
        // one dense pack on the open sensors that qualifies a reading.
        write_settings(16'd6, 8'd0, 16'd0, 16'd777, 4'b0010, 1'b0, 1'b1, 16'd0);
        send_item(OP_TICK, 2'd0);
        send_item(OP_TICK, 2'd0);
        send_item(OP_EDGE, 2'd1);
        for (int i = 0; i < 21; i++)
            send_item(OP_EDGE, open_set[i % 3]);
        drain();

        steady = 1'b1;
        run_phase(16'd60, 8'd4, 16'd6, 16'hFFFF, 4'b0000, 1'b0, 1'b1, 16'd3, 150, 70);
        steady = 1'b0;
        run_phase(16'd2, 8'd0, 16'd0, 16'd0, 4'b1111, 1'b0, 1'b1, 16'd0, 60, 50);
        run_phase(16'd50, 8'd2, 16'd3, 16'd1234, 4'b0101, 1'b1, 1'b1, 16'd1, 150, 65);
        run_phase(16'd300, 8'd255, 16'hFFFF, 16'd1, 4'b1000, 1'b0, 1'b0, 16'hFFFF, 120, 50);
        run_phase(16'd80, 8'd0, 16'd0, 16'd540, 4'b0110, 1'b0, 1'b1, 16'd2, 150, 75);
        run_phase(16'hFFFF, 8'd10, 16'd20, 16'd42, 4'b0000, 1'b0, 1'b1, 16'd5, 150, 60);
        run_phase(16'd64, 8'd3, 16'd4, 16'hFFFF, 4'b0000, 1'b1, 1'b1, 16'd4, 200, 70);
        run_phase(16'd200, 8'd1, 16'd1, 16'd300, 4'b0000, 1'b0, 1'b1, 16'hFFFF, 320, 95);

        repeat (8) @(posedge clk);
        board.close_out();
        $display("Checked %0d results from %0d items across %0d register settings.",
                 board.checked, board.items, settings_used);
        $display("Qualified pack readings: %0d; highest pulse count reached: %0d.",
                 board.readings, board.peak_count);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
